// ----- hw/rtl/aieu_pkg.sv -----
`default_nettype none
package aieu_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int NUM_REGS  = 32;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int REG_AW    = $clog2(NUM_REGS);

    // Operation codes of the func field.
    localparam logic [5:0] F_IMM_BASE = 6'd10;
    localparam logic [5:0] F_LI       = 6'd20;
    localparam logic [5:0] F_LW       = 6'd21;
    localparam logic [5:0] F_LH       = 6'd22;
    localparam logic [5:0] F_LB       = 6'd23;
    localparam logic [5:0] F_SW       = 6'd24;
    localparam logic [5:0] F_SH       = 6'd25;
    localparam logic [5:0] F_SB       = 6'd26;
    localparam logic [5:0] F_J        = 6'd27;
    localparam logic [5:0] F_CALL     = 6'd28;
    localparam logic [5:0] F_RET      = 6'd29;
    localparam logic [5:0] F_BEQ      = 6'd30;
    localparam logic [5:0] F_BNE      = 6'd31;
    localparam logic [5:0] F_BLT      = 6'd32;
    localparam logic [5:0] F_BGE      = 6'd33;
    localparam logic [5:0] F_BLE      = 6'd34;
    localparam logic [5:0] F_BGT      = 6'd35;
    localparam logic [5:0] F_ECALL    = 6'd36;

    // ALU operation codes, shared by register and immediate forms.
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_XOR = 4'd2;
    localparam logic [3:0] OP_OR  = 4'd3;
    localparam logic [3:0] OP_AND = 4'd4;
    localparam logic [3:0] OP_SLL = 4'd5;
    localparam logic [3:0] OP_SRL = 4'd6;
    localparam logic [3:0] OP_MUL = 4'd7;
    localparam logic [3:0] OP_DIV = 4'd8;
    localparam logic [3:0] OP_REM = 4'd9;

    localparam logic [4:0] REG_RA = 5'd1;
    localparam logic [4:0] REG_SP = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A1 = 5'd11;

    localparam logic [31:0] EC_EXIT       = 32'd10;
    localparam logic [31:0] EC_PRINT_INT  = 32'd1;
    localparam logic [31:0] EC_PRINT_CHAR = 32'd11;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_PAST_END = 2'd2;
    localparam logic [1:0] STAT_DIV_ZERO = 2'd3;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_INT  = 2'd1;
    localparam logic [1:0] PK_CHAR = 2'd2;

    typedef struct packed {
        logic [5:0]         func;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [15:0]        target_index;
        logic [15:0]        return_index;
    } in_t;

    typedef struct packed {
        logic [15:0]        next_index;
        logic               jumped;
        logic [1:0]         status;
        logic               finished;
        logic [1:0]         print_kind;
        logic signed [31:0] print_value;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_DIV,
        S_LRD,
        S_LCAP,
        S_SWR,
        S_FIN
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/aieu_ram.sv -----
`default_nettype none
module aieu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/assembly_instruction_execute_unit.sv -----
`default_nettype none
// Integer execute stage for decoded RV32IM-style instructions. One transfer on
// the s_ channel carries one decoded instruction and produces exactly one
// transfer on the m_ channel with the next instruction index, the redirect
// flag, the error status, the finish flag and any print request. The 32-entry
// register file lives in two copies of a synchronous RAM so that both source
// operands are read together; valid bits give reset values (zero, and the
// memory size for sp) to entries not yet written. Data memory is a byte-wide
// RAM accessed one byte at a time. One instruction is handled at a time: ALU,
// multiply, jump, branch and ecall pass through accept, register read, execute
// and write back; divide and remainder add divider steps between execute and
// write back, where the restoring divider retires one quotient bit per cycle;
// loads add a read and a capture step for each byte and stores a write step
// for each byte, set by the single data memory port. The block accepts the
// next instruction while a finished result is still waiting on the m_ channel.
module assembly_instruction_execute_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire aieu_pkg::in_t  s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output aieu_pkg::out_t    m_data
);
    import aieu_pkg::*;

    localparam logic [31:0] MEM_SIZE = 32'(MEM_BYTES);

    state_t state_reg, state_next;
    in_t    ins_reg, ins_next;
    out_t   out_reg, out_next;
    out_t   mdata_reg, mdata_next;
    logic   mv_reg, mv_next;

    logic [NUM_REGS-1:0] vld_reg, vld_next;
    logic [REG_AW-1:0]   rqa_reg, rqa_next, rqb_reg, rqb_next;
    logic [REG_AW-1:0]   raddr_a, raddr_b;
    logic [31:0]         rdata_a, rdata_b;
    logic                rf_we;

    logic [31:0]       res_reg, res_next;
    logic              wen_reg, wen_next;
    logic [4:0]        wad_reg, wad_next;
    logic [MEM_AW-1:0] addr_reg, addr_next;
    logic [1:0]        cnt_reg, cnt_next, last_reg, last_next;
    logic [31:0]       ld_reg, ld_next, st_reg, st_next;

    logic [31:0] dq_reg, dq_next, dr_reg, dr_next, dd_reg, dd_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic        qneg_reg, qneg_next, rneg_reg, rneg_next, isrem_reg, isrem_next;

    logic [MEM_AW-1:0] dm_addr;
    logic              dm_we;
    logic [7:0]        dm_wdata, dm_rdata;

    logic [31:0] a, b, opb, alu_res, raw, q_new, r_new, ld_new;
    logic [3:0]  op;
    logic [32:0] div_sh;
    logic        div_ge, take;
    logic [2:0]  nbytes;

    aieu_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
        .aclk(aclk), .we(rf_we), .waddr(wad_reg), .wdata(res_reg),
        .raddr(raddr_a), .rdata(rdata_a)
    );
    aieu_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
        .aclk(aclk), .we(rf_we), .waddr(wad_reg), .wdata(res_reg),
        .raddr(raddr_b), .rdata(rdata_b)
    );
    aieu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
        .aclk(aclk), .we(dm_we), .waddr(dm_addr), .wdata(dm_wdata),
        .raddr(dm_addr), .rdata(dm_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = mdata_reg;

    // Port A serves the first source, ra for ret and a0 for ecall. Port B
    // serves the second source, the store data register and a1 for ecall.
    always_comb begin
        raddr_a = ins_reg.src1_reg;
        raddr_b = ins_reg.src2_reg;
        if (ins_reg.func == F_ECALL) begin
            raddr_a = REG_A0;
            raddr_b = REG_A1;
        end else if (ins_reg.func == F_RET) begin
            raddr_a = REG_RA;
        end else if (ins_reg.func >= F_SW && ins_reg.func <= F_SB) begin
            raddr_b = ins_reg.dest_reg;
        end
    end

    // Entries never written read as their reset value.
    assign a = vld_reg[rqa_reg] ? rdata_a : ((rqa_reg == REG_SP) ? MEM_SIZE : 32'd0);
    assign b = vld_reg[rqb_reg] ? rdata_b : ((rqb_reg == REG_SP) ? MEM_SIZE : 32'd0);

    assign op  = (ins_reg.func < F_IMM_BASE) ? ins_reg.func[3:0]
                                             : 4'(ins_reg.func - F_IMM_BASE);
    assign opb = (ins_reg.func < F_IMM_BASE) ? b : ins_reg.immediate;
    assign raw = a + ins_reg.immediate;

    always_comb begin
        case (op)
            OP_ADD:  alu_res = a + opb;
            OP_SUB:  alu_res = a - opb;
            OP_XOR:  alu_res = a ^ opb;
            OP_OR:   alu_res = a | opb;
            OP_AND:  alu_res = a & opb;
            OP_SLL:  alu_res = a << opb[4:0];
            OP_SRL:  alu_res = a >> opb[4:0];
            OP_MUL:  alu_res = a * opb;
            default: alu_res = 32'd0;
        endcase
    end

    always_comb begin
        case (ins_reg.func)
            F_BEQ:   take = (a == b);
            F_BNE:   take = (a != b);
            F_BLT:   take = ($signed(a) < $signed(b));
            F_BGE:   take = ($signed(a) >= $signed(b));
            F_BLE:   take = ($signed(a) <= $signed(b));
            default: take = ($signed(a) > $signed(b));
        endcase
    end

    always_comb begin
        case (ins_reg.func)
            F_LW, F_SW: nbytes = 3'd4;
            F_LH, F_SH: nbytes = 3'd2;
            default:    nbytes = 3'd1;
        endcase
    end

    // One restoring divider step on magnitudes.
    assign div_sh = {dr_reg, dq_reg[31]};
    assign div_ge = (div_sh >= {1'b0, dd_reg});
    assign r_new  = div_ge ? 32'(div_sh - {1'b0, dd_reg}) : div_sh[31:0];
    assign q_new  = {dq_reg[30:0], div_ge};

    always_comb begin
        ld_new = ld_reg;
        case (cnt_reg)
            2'd0:    ld_new[7:0]   = dm_rdata;
            2'd1:    ld_new[15:8]  = dm_rdata;
            2'd2:    ld_new[23:16] = dm_rdata;
            default: ld_new[31:24] = dm_rdata;
        endcase
    end

    always_comb begin
        case (cnt_reg)
            2'd0:    dm_wdata = st_reg[7:0];
            2'd1:    dm_wdata = st_reg[15:8];
            2'd2:    dm_wdata = st_reg[23:16];
            default: dm_wdata = st_reg[31:24];
        endcase
    end

    assign dm_addr = addr_reg + MEM_AW'(cnt_reg);

    always_comb begin
        state_next = state_reg;
        ins_next   = ins_reg;
        out_next   = out_reg;
        mdata_next = mdata_reg;
        mv_next    = mv_reg;
        vld_next   = vld_reg;
        rqa_next   = rqa_reg;
        rqb_next   = rqb_reg;
        res_next   = res_reg;
        wen_next   = wen_reg;
        wad_next   = wad_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        ld_next    = ld_reg;
        st_next    = st_reg;
        dq_next    = dq_reg;
        dr_next    = dr_reg;
        dd_next    = dd_reg;
        dcnt_next  = dcnt_reg;
        qneg_next  = qneg_reg;
        rneg_next  = rneg_reg;
        isrem_next = isrem_reg;
        rf_we      = 1'b0;
        dm_we      = 1'b0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ins_next   = s_data;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                rqa_next   = raddr_a;
                rqb_next   = raddr_b;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                out_next.next_index  = ins_reg.return_index;
                out_next.jumped      = 1'b0;
                out_next.status      = STAT_OK;
                out_next.finished    = 1'b0;
                out_next.print_kind  = PK_NONE;
                out_next.print_value = 32'sd0;
                wen_next   = 1'b0;
                wad_next   = ins_reg.dest_reg;
                state_next = S_FIN;
                if (ins_reg.func < F_LI) begin
                    if (op == OP_DIV || op == OP_REM) begin
                        if (opb == 32'd0) begin
                            out_next.status = STAT_DIV_ZERO;
                        end else begin
                            dq_next    = a[31] ? -a : a;
                            dd_next    = opb[31] ? -opb : opb;
                            dr_next    = 32'd0;
                            dcnt_next  = 5'd0;
                            qneg_next  = a[31] ^ opb[31];
                            rneg_next  = a[31];
                            isrem_next = (op == OP_REM);
                            state_next = S_DIV;
                        end
                    end else begin
                        res_next = alu_res;
                        wen_next = 1'b1;
                    end
                end else if (ins_reg.func == F_LI) begin
                    res_next = ins_reg.immediate;
                    wen_next = 1'b1;
                end else if (ins_reg.func <= F_SB) begin
                    if (raw[31] || raw >= MEM_SIZE) begin
                        out_next.status = STAT_RANGE;
                    end else if ((MEM_SIZE - raw) < 32'(nbytes)) begin
                        out_next.status = STAT_PAST_END;
                    end else begin
                        addr_next  = raw[MEM_AW-1:0];
                        cnt_next   = 2'd0;
                        last_next  = 2'(nbytes - 3'd1);
                        ld_next    = 32'd0;
                        st_next    = b;
                        state_next = (ins_reg.func <= F_LB) ? S_LRD : S_SWR;
                    end
                end else if (ins_reg.func == F_J) begin
                    out_next.next_index = ins_reg.target_index;
                    out_next.jumped     = 1'b1;
                end else if (ins_reg.func == F_CALL) begin
                    out_next.next_index = ins_reg.target_index;
                    out_next.jumped     = 1'b1;
                    res_next = {16'd0, ins_reg.return_index};
                    wad_next = REG_RA;
                    wen_next = 1'b1;
                end else if (ins_reg.func == F_RET) begin
                    out_next.next_index = a[15:0];
                    out_next.jumped     = 1'b1;
                end else if (ins_reg.func <= F_BGT) begin
                    if (take) begin
                        out_next.next_index = ins_reg.target_index;
                        out_next.jumped     = 1'b1;
                    end
                end else if (ins_reg.func == F_ECALL) begin
                    if (a == EC_EXIT) begin
                        out_next.finished = 1'b1;
                    end else if (a == EC_PRINT_INT) begin
                        out_next.print_kind  = PK_INT;
                        out_next.print_value = b;
                    end else if (a == EC_PRINT_CHAR) begin
                        out_next.print_kind  = PK_CHAR;
                        out_next.print_value = b;
                    end
                end
            end
            S_DIV: begin
                dq_next   = q_new;
                dr_next   = r_new;
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd31) begin
                    if (isrem_reg) begin
                        res_next = rneg_reg ? -r_new : r_new;
                    end else begin
                        res_next = qneg_reg ? -q_new : q_new;
                    end
                    wen_next   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_LRD: begin
                state_next = S_LCAP;
            end
            S_LCAP: begin
                ld_next = ld_new;
                if (cnt_reg == last_reg) begin
                    case (last_reg)
                        2'd0:    res_next = {{24{ld_new[7]}}, ld_new[7:0]};
                        2'd1:    res_next = {{16{ld_new[15]}}, ld_new[15:0]};
                        default: res_next = ld_new;
                    endcase
                    wen_next   = 1'b1;
                    state_next = S_FIN;
                end else begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = S_LRD;
                end
            end
            S_SWR: begin
                dm_we = 1'b1;
                if (cnt_reg == last_reg) begin
                    state_next = S_FIN;
                end else begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            S_FIN: begin
                // Write back and post the result once the output is free.
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mdata_next = out_reg;
                    if (wen_reg && wad_reg != 5'd0) begin
                        rf_we             = 1'b1;
                        vld_next[wad_reg] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            vld_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            vld_reg   <= vld_next;
        end
        ins_reg    <= ins_next;
        out_reg    <= out_next;
        mdata_reg  <= mdata_next;
        rqa_reg    <= rqa_next;
        rqb_reg    <= rqb_next;
        res_reg    <= res_next;
        wen_reg    <= wen_next;
        wad_reg    <= wad_next;
        addr_reg   <= addr_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
        ld_reg     <= ld_next;
        st_reg     <= st_next;
        dq_reg     <= dq_next;
        dr_reg     <= dr_next;
        dd_reg     <= dd_next;
        dcnt_reg   <= dcnt_next;
        qneg_reg   <= qneg_next;
        rneg_reg   <= rneg_next;
        isrem_reg  <= isrem_next;
    end

    // An accepted instruction always goes to the register read cycle.
    a_accept_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_RD))
        else $error("accepted instruction did not start a register read");

    // The divider leaves only toward write back.
    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |=> (state_reg == S_DIV || state_reg == S_FIN))
        else $error("divider left to an unexpected state");

    // Register writes happen only at write back and never to x0.
    a_rf_write: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_we |-> (state_reg == S_FIN && wad_reg != 5'd0 && state_next == S_IDLE))
        else $error("register file written outside write back");

    // A new result is posted only when the previous one is gone or leaving.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready && state_reg == S_FIN) |=> (state_reg == S_FIN))
        else $error("result posted over a pending transfer");
endmodule
`default_nettype wire
